FILE: rtl/core/qph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types, codes and constants of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
package qph_pkg;

	localparam int CAP_W  = 10;
	localparam int HASH_W = 32;
	localparam int BLK_W  = 32;
	localparam int MODE_W = 2;
	localparam int ST_W   = 3;
	localparam int TAG_W  = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
	localparam logic [ST_W-1:0] ST_MISS    = 3'd3;
	localparam logic [ST_W-1:0] ST_EXHAUST = 3'd4;

	localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
	localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
	localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

	localparam logic [CAP_W-1:0] MAX_PRIME_CAP = 10'd1009;
	localparam logic [CAP_W-1:0] CAP_RESET     = 10'd101;
	localparam logic [CAP_W-1:0] CAP_FLOOR     = 10'd2;

	localparam logic [1:0] ASEL_CLR  = 2'd0;
	localparam logic [1:0] ASEL_IDX  = 2'd1;
	localparam logic [1:0] ASEL_SCAN = 2'd2;

	localparam logic [2:0] WSEL_EMPTY = 3'd0;
	localparam logic [2:0] WSEL_NEW   = 3'd1;
	localparam logic [2:0] WSEL_TOMB  = 3'd2;
	localparam logic [2:0] WSEL_UPD   = 3'd3;
	localparam logic [2:0] WSEL_MOVE  = 3'd4;

	localparam int NPRIMES = 169;
	localparam int PIDX_W  = $clog2(NPRIMES);

	localparam logic [CAP_W-1:0] PRIMES [NPRIMES] = '{
		10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
		10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
		10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109,
		10'd113, 10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163,
		10'd167, 10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211,
		10'd223, 10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
		10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313,
		10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373,
		10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431,
		10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479,
		10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547,
		10'd557, 10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601,
		10'd607, 10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653,
		10'd659, 10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
		10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769, 10'd773,
		10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827, 10'd829, 10'd839,
		10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907,
		10'd911, 10'd919, 10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971,
		10'd977, 10'd983, 10'd991, 10'd997, 10'd1009
	};

	typedef struct packed {
		logic       sel_new;
		logic       clr_rst;
		logic       clr_step;
		logic       load;
		logic       div_start;
		logic       div_src_rd;
		logic       probe_init;
		logic       adv;
		logic       rd;
		logic       wr;
		logic [2:0] wsel;
		logic [1:0] asel;
		logic       live_inc;
		logic       live_dec;
		logic       set_st;
		logic [2:0] st;
		logic       found_load;
		logic       np_rst;
		logic       np_step;
		logic       np_take;
		logic       scan_rst;
		logic       scan_inc;
		logic       ent_load;
		logic       swap;
		logic       out_load;
	} qph_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] tag;
		logic       match;
		logic       exhaust;
		logic       full;
		logic       need_rehash;
		logic       clr_last;
		logic       np_hit;
		logic       scan_end;
		logic       div_busy;
	} qph_sts_t;

endpackage

FILE: rtl/core/quadratic_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing table of (name key, disk block) entries with quadratic
// probing, tombstone removal and rehash into a second bank.
// ----------------------------------------------------------------------------
// One request is handled at a time and answers with one beat. A request
// normally reduces its hash mod capacity in the serial remainder unit and
// then probes slots on the single-port slot memory, reading and then
// evaluating each probed slot; an insert into a full table answers without
// probing. An insert at a load above three quarters first rehashes: it
// walks the prime table, clears the new bank, scans the old slots and moves
// the live entries through the remainder unit and a probe of the new bank.
// After reset and after every capacity write on cfg_we the block clears the
// slots in use, one per cycle, and takes no request meanwhile. A finished
// beat waits in an output register, so the next request can be taken while
// it is still stalled.
module quadratic_probe_hash_table_unit #(
	parameter int BANK_DEPTH = 1024,
	parameter int MIN_PRIME  = 101,
	parameter int KEY_BITS   = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qph_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [qph_pkg::MODE_W-1:0]        mode,
	input  logic [63:0]                       name_key,
	input  logic [qph_pkg::HASH_W-1:0]        name_hash,
	input  logic signed [qph_pkg::BLK_W-1:0]  disk_block,
	input  logic signed [qph_pkg::BLK_W-1:0]  new_block,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [qph_pkg::ST_W-1:0]          status,
	output logic signed [qph_pkg::BLK_W-1:0]  found_block,
	output logic [qph_pkg::CAP_W-1:0]         entry_count,
	output logic [qph_pkg::CAP_W-1:0]         table_capacity
);
	import qph_pkg::*;

	qph_cmd_t         cmd;
	qph_sts_t         sts;
	logic [BLK_W-1:0] found_u;

	qph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	qph_dp #(
		.BANK_DEPTH (BANK_DEPTH),
		.MIN_PRIME  (MIN_PRIME),
		.KEY_BITS   (KEY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.name_key       (name_key),
		.name_hash      (name_hash),
		.disk_block     (disk_block),
		.new_block      (new_block),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.found_block    (found_u),
		.entry_count    (entry_count),
		.table_capacity (table_capacity)
	);

	assign found_block = found_u;

endmodule

FILE: rtl/core/qph_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_mod
// Serial remainder unit: hash mod capacity, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module qph_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [qph_pkg::HASH_W-1:0] dividend,
	input  logic [qph_pkg::CAP_W-1:0]  divisor,
	output logic                       busy,
	output logic [qph_pkg::CAP_W-1:0]  rem
);
	import qph_pkg::*;

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [CAP_W-1:0]  dsr_q;
	logic [CAP_W-1:0]  rem_q;
	logic [CAP_W:0]    r_sh;
	logic [CAP_W:0]    r_n;

	assign r_sh = {rem_q, dvd_q[HASH_W-1]};
	assign r_n  = (r_sh >= {1'b0, dsr_q}) ? r_sh - {1'b0, dsr_q} : r_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= r_n[CAP_W-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/qph_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_dp
// Datapath: slot memory, probe arithmetic, prime walk, counters, result regs.
// ----------------------------------------------------------------------------
module qph_dp #(
	parameter int BANK_DEPTH = 1024,
	parameter int MIN_PRIME  = 101,
	parameter int KEY_BITS   = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [qph_pkg::CAP_W-1:0]  cfg_data,
	input  logic [qph_pkg::MODE_W-1:0] mode,
	input  logic [63:0]                name_key,
	input  logic [qph_pkg::HASH_W-1:0] name_hash,
	input  logic [qph_pkg::BLK_W-1:0]  disk_block,
	input  logic [qph_pkg::BLK_W-1:0]  new_block,
	input  qph_pkg::qph_cmd_t          cmd,
	output qph_pkg::qph_sts_t          sts,
	output logic [qph_pkg::ST_W-1:0]   status,
	output logic [qph_pkg::BLK_W-1:0]  found_block,
	output logic [qph_pkg::CAP_W-1:0]  entry_count,
	output logic [qph_pkg::CAP_W-1:0]  table_capacity
);
	import qph_pkg::*;

	localparam int IDX_W  = $clog2(BANK_DEPTH);
	localparam int ADDR_W = IDX_W + 1;
	localparam int ENT_W  = KEY_BITS + HASH_W + BLK_W;
	localparam int WORD_W = TAG_W + ENT_W;
	localparam logic [CAP_W-1:0] CAP_LIM =
		(BANK_DEPTH < 1009) ? CAP_W'(BANK_DEPTH) : MAX_PRIME_CAP;
	localparam logic [CAP_W-1:0] CAP_INIT = (CAP_RESET > CAP_LIM) ? CAP_LIM : CAP_RESET;
	localparam logic [CAP_W:0] MIN_LO = (CAP_W + 1)'(MIN_PRIME);

	logic [WORD_W-1:0] mem [2*BANK_DEPTH];

	logic                bank_q;
	logic [CAP_W-1:0]    cap_q, live_q, newcap_q, clr_q, scan_q;
	logic [PIDX_W-1:0]   pj_q;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [HASH_W-1:0]   hash_q;
	logic [BLK_W-1:0]    blk_q, nblk_q;
	logic [CAP_W-1:0]    idx_q, step_q, sq_q, d_q;
	logic [ENT_W-1:0]    ent_q;
	logic [WORD_W-1:0]   rd_q;
	logic [ST_W-1:0]     res_st_q, status_q;
	logic [BLK_W-1:0]    res_found_q, found_q;
	logic [CAP_W-1:0]    count_q, capo_q;

	logic [CAP_W-1:0]    pcap, idx_n, sq_n, d_n, step_n, d_init, isel, cfg_lim;
	logic [CAP_W-1:0]    prime, newcap_n;
	logic [CAP_W:0]      idx_sum, sq_sum, d_sum, lo, twocap1;
	logic [ADDR_W-1:0]   addr;
	logic [WORD_W-1:0]   wdata;
	logic [TAG_W-1:0]    rd_tag;
	logic [KEY_BITS-1:0] rd_key;
	logic [HASH_W-1:0]   rd_hash;
	logic [BLK_W-1:0]    rd_blk;
	logic [CAP_W+1:0]    live4, cap3;
	logic                div_busy;
	logic [CAP_W-1:0]    div_rem;

	assign rd_tag  = rd_q[WORD_W-1 -: TAG_W];
	assign rd_key  = rd_q[ENT_W-1 -: KEY_BITS];
	assign rd_hash = rd_q[BLK_W +: HASH_W];
	assign rd_blk  = rd_q[BLK_W-1:0];

	assign pcap = cmd.sel_new ? newcap_q : cap_q;

	// probe advance: idx += step^2, step^2 kept incrementally mod capacity
	assign idx_sum = {1'b0, idx_q} + {1'b0, sq_q};
	assign idx_n   = (idx_sum >= {1'b0, pcap}) ? CAP_W'(idx_sum - {1'b0, pcap})
		: CAP_W'(idx_sum);
	assign sq_sum  = {1'b0, sq_q} + {1'b0, d_q};
	assign sq_n    = (sq_sum >= {1'b0, pcap}) ? CAP_W'(sq_sum - {1'b0, pcap})
		: CAP_W'(sq_sum);
	assign d_sum   = {1'b0, d_q} + (CAP_W + 1)'(2);
	assign d_n     = (d_sum >= {1'b0, pcap}) ? CAP_W'(d_sum - {1'b0, pcap})
		: CAP_W'(d_sum);
	assign step_n  = step_q + CAP_W'(1);
	assign d_init  = (pcap > CAP_W'(3)) ? CAP_W'(3) : CAP_W'(3) - pcap;

	assign twocap1  = {cap_q, 1'b1};
	assign lo       = (twocap1 > MIN_LO) ? twocap1 : MIN_LO;
	assign prime    = PRIMES[pj_q];
	assign newcap_n = (prime > CAP_LIM) ? CAP_LIM : prime;

	assign cfg_lim = (cfg_data < CAP_FLOOR) ? CAP_FLOOR
		: ((cfg_data > CAP_LIM) ? CAP_LIM : cfg_data);

	assign live4 = {live_q, 2'b00};
	assign cap3  = {1'b0, cap_q, 1'b0} + {2'b00, cap_q};

	always_comb begin
		case (cmd.asel)
			ASEL_CLR:  isel = clr_q;
			ASEL_SCAN: isel = scan_q;
			default:   isel = idx_q;
		endcase
	end

	assign addr = {bank_q ^ cmd.sel_new, IDX_W'(isel)};

	always_comb begin
		case (cmd.wsel)
			WSEL_NEW:  wdata = {TAG_LIVE, key_q, hash_q, blk_q};
			WSEL_TOMB: wdata = {TAG_TOMB, rd_q[ENT_W-1:0]};
			WSEL_UPD:  wdata = {TAG_LIVE, rd_q[ENT_W-1:BLK_W], nblk_q};
			WSEL_MOVE: wdata = {TAG_LIVE, ent_q};
			default:   wdata = {TAG_EMPTY, ENT_W'(0)};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	qph_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_src_rd ? rd_hash : hash_q),
		.divisor  (pcap),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			cap_q    <= CAP_INIT;
			live_q   <= '0;
			newcap_q <= CAP_INIT;
			clr_q    <= '0;
			scan_q   <= '0;
			pj_q     <= '0;
		end else if (cfg_we) begin
			bank_q <= 1'b0;
			cap_q  <= cfg_lim;
			live_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_rst) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + CAP_W'(1);
			end
			if (cmd.live_inc) begin
				live_q <= live_q + CAP_W'(1);
			end else if (cmd.live_dec && live_q != '0) begin
				live_q <= live_q - CAP_W'(1);
			end
			if (cmd.np_rst) begin
				pj_q <= '0;
			end else if (cmd.np_step) begin
				pj_q <= pj_q + PIDX_W'(1);
			end
			if (cmd.np_take) begin
				newcap_q <= newcap_n;
			end
			if (cmd.scan_rst) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + CAP_W'(1);
			end
			if (cmd.swap) begin
				bank_q <= ~bank_q;
				cap_q  <= newcap_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= mode;
			key_q       <= name_key[KEY_BITS-1:0];
			hash_q      <= name_hash;
			blk_q       <= disk_block;
			nblk_q      <= new_block;
			res_found_q <= '0;
		end else if (cmd.found_load) begin
			res_found_q <= rd_blk;
		end
		if (cmd.probe_init) begin
			idx_q  <= div_rem;
			step_q <= CAP_W'(1);
			sq_q   <= CAP_W'(1);
			d_q    <= d_init;
		end else if (cmd.adv) begin
			idx_q  <= idx_n;
			step_q <= step_n;
			sq_q   <= sq_n;
			d_q    <= d_n;
		end
		if (cmd.ent_load) begin
			ent_q <= rd_q[ENT_W-1:0];
		end
		if (cmd.set_st) begin
			res_st_q <= cmd.st;
		end
		if (cmd.out_load) begin
			status_q <= res_st_q;
			found_q  <= res_found_q;
			count_q  <= live_q;
			capo_q   <= cap_q;
		end
	end

	always_comb begin
		sts.mode        = mode_q;
		sts.tag         = rd_tag;
		sts.match       = (rd_key == key_q) && (rd_blk == blk_q);
		sts.exhaust     = step_n > pcap;
		sts.full        = live_q >= cap_q;
		sts.need_rehash = live4 > cap3;
		sts.clr_last    = clr_q == (pcap - CAP_W'(1));
		sts.np_hit      = ({1'b0, prime} >= lo) || (pj_q == PIDX_W'(NPRIMES - 1));
		sts.scan_end    = scan_q == cap_q;
		sts.div_busy    = div_busy;
	end

	assign status         = status_q;
	assign found_block    = found_q;
	assign entry_count    = count_q;
	assign table_capacity = capo_q;

endmodule

FILE: rtl/core/qph_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_ctrl
// Controller: sequences clearing, probing, rehash and result hand-off.
// ----------------------------------------------------------------------------
module qph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  qph_pkg::qph_sts_t sts,
	output qph_pkg::qph_cmd_t cmd
);
	import qph_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_HDIV  = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_EV    = 4'd5;
	localparam logic [3:0] S_NP    = 4'd6;
	localparam logic [3:0] S_RCLR  = 4'd7;
	localparam logic [3:0] S_RSCAN = 4'd8;
	localparam logic [3:0] S_RTAG  = 4'd9;
	localparam logic [3:0] S_RDIV  = 4'd10;
	localparam logic [3:0] S_RPRD  = 4'd11;
	localparam logic [3:0] S_RPEV  = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0] state_q, state_n;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.wr       = 1'b1;
				cmd.wsel     = WSEL_EMPTY;
				cmd.asel     = ASEL_CLR;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.mode == MODE_INSERT && sts.full) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_FULL;
					state_n    = S_OUT;
				end else if (sts.mode == MODE_INSERT && sts.need_rehash) begin
					cmd.np_rst = 1'b1;
					state_n    = S_NP;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_HDIV;
				end
			end
			S_HDIV: begin
				if (!sts.div_busy) begin
					cmd.probe_init = 1'b1;
					state_n        = S_RD;
				end
			end
			S_RD: begin
				cmd.rd   = 1'b1;
				cmd.asel = ASEL_IDX;
				state_n  = S_EV;
			end
			S_EV: begin
				cmd.asel = ASEL_IDX;
				if (sts.mode == MODE_INSERT) begin
					if (sts.tag == TAG_LIVE) begin
						if (sts.match) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_DUP;
							state_n    = S_OUT;
						end else begin
							cmd.adv = 1'b1;
							if (sts.exhaust) begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_EXHAUST;
								state_n    = S_OUT;
							end else begin
								state_n = S_RD;
							end
						end
					end else begin
						cmd.wr       = 1'b1;
						cmd.wsel     = WSEL_NEW;
						cmd.live_inc = 1'b1;
						cmd.set_st   = 1'b1;
						cmd.st       = ST_OK;
						state_n      = S_OUT;
					end
				end else if (sts.tag == TAG_EMPTY) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_MISS;
					state_n    = S_OUT;
				end else if (sts.tag == TAG_LIVE && sts.match) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OK;
					state_n    = S_OUT;
					case (sts.mode)
						MODE_REMOVE: begin
							cmd.wr       = 1'b1;
							cmd.wsel     = WSEL_TOMB;
							cmd.live_dec = 1'b1;
						end
						MODE_LOOKUP: begin
							cmd.found_load = 1'b1;
						end
						default: begin
							cmd.wr   = 1'b1;
							cmd.wsel = WSEL_UPD;
						end
					endcase
				end else begin
					cmd.adv = 1'b1;
					if (sts.exhaust) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_MISS;
						state_n    = S_OUT;
					end else begin
						state_n = S_RD;
					end
				end
			end
			S_NP: begin
				if (sts.np_hit) begin
					cmd.np_take = 1'b1;
					cmd.clr_rst = 1'b1;
					state_n     = S_RCLR;
				end else begin
					cmd.np_step = 1'b1;
				end
			end
			S_RCLR: begin
				cmd.sel_new  = 1'b1;
				cmd.wr       = 1'b1;
				cmd.wsel     = WSEL_EMPTY;
				cmd.asel     = ASEL_CLR;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.scan_rst = 1'b1;
					state_n      = S_RSCAN;
				end
			end
			S_RSCAN: begin
				if (sts.scan_end) begin
					cmd.sel_new   = 1'b1;
					cmd.swap      = 1'b1;
					cmd.div_start = 1'b1;
					state_n       = S_HDIV;
				end else begin
					cmd.rd   = 1'b1;
					cmd.asel = ASEL_SCAN;
					state_n  = S_RTAG;
				end
			end
			S_RTAG: begin
				if (sts.tag == TAG_LIVE) begin
					cmd.sel_new    = 1'b1;
					cmd.ent_load   = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_src_rd = 1'b1;
					state_n        = S_RDIV;
				end else begin
					cmd.scan_inc = 1'b1;
					state_n      = S_RSCAN;
				end
			end
			S_RDIV: begin
				cmd.sel_new = 1'b1;
				if (!sts.div_busy) begin
					cmd.probe_init = 1'b1;
					state_n        = S_RPRD;
				end
			end
			S_RPRD: begin
				cmd.sel_new = 1'b1;
				cmd.rd      = 1'b1;
				cmd.asel    = ASEL_IDX;
				state_n     = S_RPEV;
			end
			S_RPEV: begin
				cmd.sel_new = 1'b1;
				cmd.asel    = ASEL_IDX;
				if (sts.tag == TAG_EMPTY) begin
					cmd.wr       = 1'b1;
					cmd.wsel     = WSEL_MOVE;
					cmd.scan_inc = 1'b1;
					state_n      = S_RSCAN;
				end else begin
					cmd.adv = 1'b1;
					if (sts.exhaust) begin
						cmd.live_dec = 1'b1;
						cmd.scan_inc = 1'b1;
						state_n      = S_RSCAN;
					end else begin
						state_n = S_RPRD;
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_n = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/qph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_checker
// Port-level checks of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
module qph_assertions (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [qph_pkg::ST_W-1:0]          status,
	input logic signed [qph_pkg::BLK_W-1:0]  found_block,
	input logic [qph_pkg::CAP_W-1:0]         entry_count,
	input logic [qph_pkg::CAP_W-1:0]         table_capacity
);
	import qph_pkg::*;

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
		$stable(found_block) && $stable(entry_count) && $stable(table_capacity)))
		else $error("stalled result beat changed");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (found_block == '0))
		else $error("found block nonzero on failed request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= table_capacity && table_capacity >= CAP_FLOOR))
		else $error("entry count above capacity");

endmodule

bind quadratic_probe_hash_table_unit qph_assertions u_qph_assertions (.*);
